[rtl/sbo_pkg.sv]
// ----------------------------------------------------------------------------
// sbo_pkg
// Shared types and codes for the select-before-operate sequencer.
// ----------------------------------------------------------------------------
package sbo_pkg;

    localparam int DataW   = 16;
    localparam int CfgIdxW = 3;

    // request types
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_WRSP  = 2'd2;
    localparam logic [1:0] REQ_RRSP  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // done status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ERR     = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // points
    localparam logic PT_CONTROL  = 1'b0;
    localparam logic PT_FEEDBACK = 1'b1;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_SELECT_OFFSET       = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SELECT_FEEDBACK     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_OPERATE_OFFSET      = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_EXECUTE_FEEDBACK    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SELECT_POLL_LIMIT   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_FEEDBACK_POLL_LIMIT = 3'd5;

    localparam logic [DataW-1:0] POLL_LIMIT_RESET = 16'd10;

    // sequencer phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_SEL_WR   = 4'd1;
    localparam logic [3:0] PH_SEL_TICK = 4'd2;
    localparam logic [3:0] PH_SEL_RD   = 4'd3;
    localparam logic [3:0] PH_GAP_TICK = 4'd4;
    localparam logic [3:0] PH_OP_WR    = 4'd5;
    localparam logic [3:0] PH_EXE_TICK = 4'd6;
    localparam logic [3:0] PH_EXE_RD   = 4'd7;
    localparam logic [3:0] PH_ST_TICK  = 4'd8;
    localparam logic [3:0] PH_ST_RD    = 4'd9;

    typedef struct packed {
        logic signed [DataW-1:0] select_offset;
        logic signed [DataW-1:0] select_feedback;
        logic signed [DataW-1:0] operate_offset;
        logic signed [DataW-1:0] execute_feedback;
        logic        [DataW-1:0] select_poll_limit;
        logic        [DataW-1:0] feedback_poll_limit;
    } t_cfg;

    typedef struct packed {
        logic        [1:0]       out_kind;
        logic        [DataW-1:0] device_id;
        logic                    point_sel;
        logic signed [DataW-1:0] write_value;
        logic        [1:0]       done_status;
    } t_result;

endpackage

[rtl/sbo_cfg.sv]
// ----------------------------------------------------------------------------
// sbo_cfg
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module sbo_cfg
    import sbo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [DataW-1:0]   i_cfg_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SELECT_OFFSET:       n_cfg.select_offset       = i_cfg_data;
                CFG_SELECT_FEEDBACK:     n_cfg.select_feedback     = i_cfg_data;
                CFG_OPERATE_OFFSET:      n_cfg.operate_offset      = i_cfg_data;
                CFG_EXECUTE_FEEDBACK:    n_cfg.execute_feedback    = i_cfg_data;
                CFG_SELECT_POLL_LIMIT:   n_cfg.select_poll_limit   = i_cfg_data;
                CFG_FEEDBACK_POLL_LIMIT: n_cfg.feedback_poll_limit = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.select_offset       <= '0;
            r_cfg.select_feedback     <= '0;
            r_cfg.operate_offset      <= '0;
            r_cfg.execute_feedback    <= '0;
            r_cfg.select_poll_limit   <= POLL_LIMIT_RESET;
            r_cfg.feedback_poll_limit <= POLL_LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/sbo_seq.sv]
// ----------------------------------------------------------------------------
// sbo_seq
// Input register and phase sequencer; one registered item handled per cycle while the output queue has room.
// ----------------------------------------------------------------------------
module sbo_seq
    import sbo_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_req_type,
    input  logic signed [DataW-1:0] i_target_value,
    input  logic [DataW-1:0]        i_control_device,
    input  logic [DataW-1:0]        i_status_device,
    input  logic                    i_resp_ok,
    input  logic signed [DataW-1:0] i_read_value,
    input  t_cfg                    i_cfg,
    input  logic                    i_out_room,
    output logic                    o_push,
    output t_result                 o_result
);

    logic                    r_in_valid;
    logic [1:0]              r_req;
    logic signed [DataW-1:0] r_target;
    logic [DataW-1:0]        r_ctl;
    logic [DataW-1:0]        r_sts;
    logic                    r_ok;
    logic signed [DataW-1:0] r_rv;

    logic [3:0]              r_phase;
    logic [DataW-1:0]        r_poll;
    logic signed [DataW-1:0] r_held_target;
    logic [DataW-1:0]        r_held_ctl;
    logic [DataW-1:0]        r_held_sts;

    logic [3:0]              n_phase;
    logic [DataW-1:0]        n_poll;
    logic signed [DataW-1:0] n_held_target;
    logic [DataW-1:0]        n_held_ctl;
    logic [DataW-1:0]        n_held_sts;

    logic                    fire;
    logic                    has_res;
    t_result                 res;
    logic signed [DataW-1:0] expect_state;
    logic [DataW-1:0]        poll_inc;

    assign fire         = r_in_valid && i_out_room;
    assign o_in_stall   = r_in_valid && !i_out_room;
    assign expect_state = r_held_target + i_cfg.operate_offset;
    assign poll_inc     = r_poll + 16'd1;
    assign o_push       = fire && has_res;
    assign o_result     = res;

    always_comb begin
        n_phase       = r_phase;
        n_poll        = r_poll;
        n_held_target = r_held_target;
        n_held_ctl    = r_held_ctl;
        n_held_sts    = r_held_sts;
        has_res       = 1'b0;
        res           = '0;
        case (r_phase)
            PH_IDLE: begin
                if (r_req == REQ_START) begin
                    n_held_target   = r_target;
                    n_held_ctl      = r_ctl;
                    n_held_sts      = r_sts;
                    n_poll          = '0;
                    n_phase         = PH_SEL_WR;
                    has_res         = 1'b1;
                    res.out_kind    = KIND_WRITE;
                    res.device_id   = r_ctl;
                    res.point_sel   = PT_CONTROL;
                    res.write_value = r_target + i_cfg.select_offset;
                end
            end
            PH_SEL_WR: begin
                if (r_req == REQ_WRSP) begin
                    n_poll = '0;
                    if (!r_ok) begin
                        n_phase         = PH_IDLE;
                        has_res         = 1'b1;
                        res.out_kind    = KIND_DONE;
                        res.done_status = ST_ERR;
                    end else if (i_cfg.select_poll_limit == '0) begin
                        n_phase         = PH_IDLE;
                        has_res         = 1'b1;
                        res.out_kind    = KIND_DONE;
                        res.done_status = ST_TIMEOUT;
                    end else begin
                        n_phase = PH_SEL_TICK;
                    end
                end
            end
            PH_SEL_TICK: begin
                if (r_req == REQ_TICK) begin
                    n_phase       = PH_SEL_RD;
                    has_res       = 1'b1;
                    res.out_kind  = KIND_READ;
                    res.device_id = r_held_ctl;
                    res.point_sel = PT_CONTROL;
                end
            end
            PH_SEL_RD: begin
                if (r_req == REQ_RRSP) begin
                    if (!r_ok) begin
                        n_phase         = PH_IDLE;
                        has_res         = 1'b1;
                        res.out_kind    = KIND_DONE;
                        res.done_status = ST_ERR;
                    end else if (r_rv == i_cfg.select_feedback) begin
                        n_phase = PH_GAP_TICK;
                    end else begin
                        n_poll = poll_inc;
                        if (poll_inc >= i_cfg.select_poll_limit) begin
                            n_phase         = PH_IDLE;
                            has_res         = 1'b1;
                            res.out_kind    = KIND_DONE;
                            res.done_status = ST_TIMEOUT;
                        end else begin
                            n_phase = PH_SEL_TICK;
                        end
                    end
                end
            end
            PH_GAP_TICK: begin
                if (r_req == REQ_TICK) begin
                    n_phase         = PH_OP_WR;
                    has_res         = 1'b1;
                    res.out_kind    = KIND_WRITE;
                    res.device_id   = r_held_ctl;
                    res.point_sel   = PT_CONTROL;
                    res.write_value = expect_state;
                end
            end
            PH_OP_WR: begin
                if (r_req == REQ_WRSP) begin
                    n_poll = '0;
                    if (!r_ok || i_cfg.feedback_poll_limit == '0) begin
                        n_phase         = PH_IDLE;
                        has_res         = 1'b1;
                        res.out_kind    = KIND_DONE;
                        res.done_status = ST_ERR;
                    end else begin
                        n_phase = PH_EXE_TICK;
                    end
                end
            end
            PH_EXE_TICK: begin
                if (r_req == REQ_TICK) begin
                    n_phase       = PH_EXE_RD;
                    has_res       = 1'b1;
                    res.out_kind  = KIND_READ;
                    res.device_id = r_held_sts;
                    res.point_sel = PT_CONTROL;
                end
            end
            PH_EXE_RD: begin
                if (r_req == REQ_RRSP) begin
                    if (r_ok && r_rv == i_cfg.execute_feedback) begin
                        n_poll = '0;
                        if (i_cfg.feedback_poll_limit == '0) begin
                            n_phase         = PH_IDLE;
                            has_res         = 1'b1;
                            res.out_kind    = KIND_DONE;
                            res.done_status = ST_ERR;
                        end else begin
                            n_phase = PH_ST_TICK;
                        end
                    end else begin
                        n_poll = poll_inc;
                        if (poll_inc >= i_cfg.feedback_poll_limit) begin
                            n_phase         = PH_IDLE;
                            has_res         = 1'b1;
                            res.out_kind    = KIND_DONE;
                            res.done_status = ST_ERR;
                        end else begin
                            n_phase = PH_EXE_TICK;
                        end
                    end
                end
            end
            PH_ST_TICK: begin
                if (r_req == REQ_TICK) begin
                    n_phase       = PH_ST_RD;
                    has_res       = 1'b1;
                    res.out_kind  = KIND_READ;
                    res.device_id = r_held_sts;
                    res.point_sel = PT_FEEDBACK;
                end
            end
            PH_ST_RD: begin
                if (r_req == REQ_RRSP) begin
                    if (r_ok && r_rv == expect_state) begin
                        n_phase         = PH_IDLE;
                        has_res         = 1'b1;
                        res.out_kind    = KIND_DONE;
                        res.done_status = ST_OK;
                    end else begin
                        n_poll = poll_inc;
                        if (poll_inc >= i_cfg.feedback_poll_limit) begin
                            n_phase         = PH_IDLE;
                            has_res         = 1'b1;
                            res.out_kind    = KIND_DONE;
                            res.done_status = ST_ERR;
                        end else begin
                            n_phase = PH_ST_TICK;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_req    <= i_req_type;
            r_target <= i_target_value;
            r_ctl    <= i_control_device;
            r_sts    <= i_status_device;
            r_ok     <= i_resp_ok;
            r_rv     <= i_read_value;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_poll        <= '0;
            r_held_target <= '0;
            r_held_ctl    <= '0;
            r_held_sts    <= '0;
        end else if (fire) begin
            r_phase       <= n_phase;
            r_poll        <= n_poll;
            r_held_target <= n_held_target;
            r_held_ctl    <= n_held_ctl;
            r_held_sts    <= n_held_sts;
        end
    end

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && res.out_kind == KIND_DONE |=> r_phase == PH_IDLE)
        else $error("done result did not return sequencer to idle");

    a_start_selects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_phase == PH_IDLE && r_req == REQ_START
        |=> r_phase == PH_SEL_WR && r_poll == '0)
        else $error("start did not enter select write phase");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_phase) && $stable(r_poll))
        else $error("sequencer state moved without a transfer");

endmodule

[rtl/sbo_oq.sv]
// ----------------------------------------------------------------------------
// sbo_oq
// Two-entry result queue: output register plus skid register.
// ----------------------------------------------------------------------------
module sbo_oq
    import sbo_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_room,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_result
);

    logic    r_ov;
    logic    r_sv;
    t_result r_main;
    t_result r_skid;
    logic    n_ov;
    logic    n_sv;
    t_result n_main;
    t_result n_skid;
    logic    pop;

    assign pop         = r_ov && !i_out_stall;
    assign o_room      = !r_sv;
    assign o_out_valid = r_ov;
    assign o_result    = r_main;

    always_comb begin
        n_ov   = r_ov;
        n_sv   = r_sv;
        n_main = r_main;
        n_skid = r_skid;
        if (pop) begin
            if (r_sv) begin
                n_main = r_skid;
                n_sv   = 1'b0;
            end else begin
                n_ov = 1'b0;
            end
        end
        if (i_push) begin
            if (!n_ov) begin
                n_main = i_result;
                n_ov   = 1'b1;
            end else begin
                n_skid = i_result;
                n_sv   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry held without an output entry");

endmodule

[rtl/select_before_operate_sequencer.sv]
// ----------------------------------------------------------------------------
// select_before_operate_sequencer
// Two-point select-before-operate command sequencer.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while o_in_stall is low: start,
// tick, write response or read response. An accepted item lands in an input
// register, the phase sequencer handles it once the output queue has room,
// and any write request, read request or done result it causes is placed in
// a two-entry output queue, which presents it on o_out_valid.
// The input stalls only while an item waits in the input register and the
// output queue is full. Items that do not fit the current phase are dropped
// without a result. Configuration registers are written through the cfg
// channel, which is always ready, and must only be written while idle.
module select_before_operate_sequencer
    import sbo_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CfgIdxW-1:0]      i_cfg_index,
    input  logic [DataW-1:0]        i_cfg_data,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_req_type,
    input  logic signed [DataW-1:0] i_target_value,
    input  logic [DataW-1:0]        i_control_device,
    input  logic [DataW-1:0]        i_status_device,
    input  logic                    i_resp_ok,
    input  logic signed [DataW-1:0] i_read_value,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_out_kind,
    output logic [DataW-1:0]        o_device_id,
    output logic                    o_point_sel,
    output logic signed [DataW-1:0] o_write_value,
    output logic [1:0]              o_done_status
);

    t_cfg    cfg;
    t_result seq_result;
    t_result out_result;
    logic    push;
    logic    room;

    sbo_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sbo_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_target_value   (i_target_value),
        .i_control_device (i_control_device),
        .i_status_device  (i_status_device),
        .i_resp_ok        (i_resp_ok),
        .i_read_value     (i_read_value),
        .i_cfg            (cfg),
        .i_out_room       (room),
        .o_push           (push),
        .o_result         (seq_result)
    );

    sbo_oq u_oq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (seq_result),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_result)
    );

    assign o_out_kind    = out_result.out_kind;
    assign o_device_id   = out_result.device_id;
    assign o_point_sel   = out_result.point_sel;
    assign o_write_value = out_result.write_value;
    assign o_done_status = out_result.done_status;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the select-before-operate sequencer against an in-house predictor.
// A directed table walks the full select, operate, execute and state flow,
// the error and timeout exits and the zero poll limits. Four random phases
// then run mostly well-formed sequences under different register settings
// and idle patterns, including a long output hold-off that backs up the
// input. Every output transfer is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import sbo_pkg::*;

    typedef struct packed {
        logic [1:0]       req;
        logic [DataW-1:0] target;
        logic [DataW-1:0] ctrl;
        logic [DataW-1:0] stat;
        logic             ok;
        logic [DataW-1:0] rv;
    } t_item;

    typedef struct packed {
        logic               is_cfg;
        logic [CfgIdxW-1:0] idx;
        logic [DataW-1:0]   data;
        t_item              it;
        logic               typed;
        t_result            res;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CfgIdxW-1:0]      i_cfg_index = '0;
    logic [DataW-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [1:0]              i_req_type = '0;
    logic signed [DataW-1:0] i_target_value = '0;
    logic [DataW-1:0]        i_control_device = '0;
    logic [DataW-1:0]        i_status_device = '0;
    logic                    i_resp_ok = 1'b0;
    logic signed [DataW-1:0] i_read_value = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [1:0]              o_out_kind;
    logic [DataW-1:0]        o_device_id;
    logic                    o_point_sel;
    logic signed [DataW-1:0] o_write_value;
    logic [1:0]              o_done_status;

    select_before_operate_sequencer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_target_value   (i_target_value),
        .i_control_device (i_control_device),
        .i_status_device  (i_status_device),
        .i_resp_ok        (i_resp_ok),
        .i_read_value     (i_read_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_kind       (o_out_kind),
        .o_device_id      (o_device_id),
        .o_point_sel      (o_point_sel),
        .o_write_value    (o_write_value),
        .o_done_status    (o_done_status)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    t_cfg             reg_copy;
    logic [3:0]       sq_phase;
    logic [DataW-1:0] poll_cnt;
    logic [DataW-1:0] latched_target;
    logic [DataW-1:0] latched_ctrl;
    logic [DataW-1:0] latched_stat;

    t_result pending_results[$];
    t_result head;
    t_row    dir_rows[$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    bit      hold_pending = 1'b0;

    function automatic t_result mk_res(input logic [1:0] kind, input logic [DataW-1:0] dev,
                                       input logic pt, input logic [DataW-1:0] val,
                                       input logic [1:0] st);
        t_result r;
        r.out_kind    = kind;
        r.device_id   = dev;
        r.point_sel   = pt;
        r.write_value = val;
        r.done_status = st;
        return r;
    endfunction

    function automatic t_row it_row(input logic [1:0] req, input logic [DataW-1:0] tgt,
                                    input logic [DataW-1:0] ctrl, input logic [DataW-1:0] stat,
                                    input logic ok, input logic [DataW-1:0] rv);
        t_row r;
        r = '0;
        r.it.req    = req;
        r.it.target = tgt;
        r.it.ctrl   = ctrl;
        r.it.stat   = stat;
        r.it.ok     = ok;
        r.it.rv     = rv;
        return r;
    endfunction

    function automatic t_row with_res(input t_row r, input t_result res);
        t_row o;
        o = r;
        o.typed = 1'b1;
        o.res   = res;
        return o;
    endfunction

    function automatic t_row cfg_row(input logic [CfgIdxW-1:0] idx,
                                     input logic [DataW-1:0] data);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    task automatic reset_model;
        reg_copy                     = '0;
        reg_copy.select_poll_limit   = POLL_LIMIT_RESET;
        reg_copy.feedback_poll_limit = POLL_LIMIT_RESET;
        sq_phase       = PH_IDLE;
        poll_cnt       = '0;
        latched_target = '0;
        latched_ctrl   = '0;
        latched_stat   = '0;
    endtask

    // advance the sequencer model by one item
    task automatic advance_sequencer(input t_item it, output bit consumed,
                                     output bit has_res, output t_result res);
        logic [DataW-1:0] want;
        want     = latched_target + reg_copy.operate_offset;
        consumed = 1'b1;
        has_res  = 1'b0;
        res      = '0;
        case (sq_phase)
            PH_IDLE: begin
                if (it.req != REQ_START) begin
                    consumed = 1'b0;
                end else begin
                    latched_target = it.target;
                    latched_ctrl   = it.ctrl;
                    latched_stat   = it.stat;
                    poll_cnt       = '0;
                    sq_phase       = PH_SEL_WR;
                    has_res        = 1'b1;
                    res = mk_res(KIND_WRITE, it.ctrl, PT_CONTROL,
                                 it.target + reg_copy.select_offset, ST_OK);
                end
            end
            PH_SEL_WR: begin
                if (it.req != REQ_WRSP) begin
                    consumed = 1'b0;
                end else if (!it.ok) begin
                    has_res = 1'b1;
                    res     = mk_res(KIND_DONE, '0, 1'b0, '0, ST_ERR);
                end else begin
                    poll_cnt = '0;
                    if (reg_copy.select_poll_limit == 0) begin
                        has_res = 1'b1;
                        res     = mk_res(KIND_DONE, '0, 1'b0, '0, ST_TIMEOUT);
                    end else begin
                        sq_phase = PH_SEL_TICK;
                    end
                end
            end
            PH_SEL_TICK: begin
                if (it.req != REQ_TICK) begin
                    consumed = 1'b0;
                end else begin
                    sq_phase = PH_SEL_RD;
                    has_res  = 1'b1;
                    res      = mk_res(KIND_READ, latched_ctrl, PT_CONTROL, '0, ST_OK);
                end
            end
            PH_SEL_RD: begin
                if (it.req != REQ_RRSP) begin
                    consumed = 1'b0;
                end else if (!it.ok) begin
                    has_res = 1'b1;
                    res     = mk_res(KIND_DONE, '0, 1'b0, '0, ST_ERR);
                end else if (it.rv == reg_copy.select_feedback) begin
                    sq_phase = PH_GAP_TICK;
                end else begin
                    poll_cnt = poll_cnt + 1'b1;
                    if (poll_cnt >= reg_copy.select_poll_limit) begin
                        has_res = 1'b1;
                        res     = mk_res(KIND_DONE, '0, 1'b0, '0, ST_TIMEOUT);
                    end else begin
                        sq_phase = PH_SEL_TICK;
                    end
                end
            end
            PH_GAP_TICK: begin
                if (it.req != REQ_TICK) begin
                    consumed = 1'b0;
                end else begin
                    sq_phase = PH_OP_WR;
                    has_res  = 1'b1;
                    res      = mk_res(KIND_WRITE, latched_ctrl, PT_CONTROL, want, ST_OK);
                end
            end
            PH_OP_WR: begin
                if (it.req != REQ_WRSP) begin
                    consumed = 1'b0;
                end else if (!it.ok || reg_copy.feedback_poll_limit == 0) begin
                    poll_cnt = '0;
                    has_res  = 1'b1;
                    res      = mk_res(KIND_DONE, '0, 1'b0, '0, ST_ERR);
                end else begin
                    poll_cnt = '0;
                    sq_phase = PH_EXE_TICK;
                end
            end
            PH_EXE_TICK: begin
                if (it.req != REQ_TICK) begin
                    consumed = 1'b0;
                end else begin
                    sq_phase = PH_EXE_RD;
                    has_res  = 1'b1;
                    res      = mk_res(KIND_READ, latched_stat, PT_CONTROL, '0, ST_OK);
                end
            end
            PH_EXE_RD: begin
                if (it.req != REQ_RRSP) begin
                    consumed = 1'b0;
                end else if (it.ok && it.rv == reg_copy.execute_feedback) begin
                    poll_cnt = '0;
                    if (reg_copy.feedback_poll_limit == 0) begin
                        has_res = 1'b1;
                        res     = mk_res(KIND_DONE, '0, 1'b0, '0, ST_ERR);
                    end else begin
                        sq_phase = PH_ST_TICK;
                    end
                end else begin
                    poll_cnt = poll_cnt + 1'b1;
                    if (poll_cnt >= reg_copy.feedback_poll_limit) begin
                        has_res = 1'b1;
                        res     = mk_res(KIND_DONE, '0, 1'b0, '0, ST_ERR);
                    end else begin
                        sq_phase = PH_EXE_TICK;
                    end
                end
            end
            PH_ST_TICK: begin
                if (it.req != REQ_TICK) begin
                    consumed = 1'b0;
                end else begin
                    sq_phase = PH_ST_RD;
                    has_res  = 1'b1;
                    res      = mk_res(KIND_READ, latched_stat, PT_FEEDBACK, '0, ST_OK);
                end
            end
            PH_ST_RD: begin
                if (it.req != REQ_RRSP) begin
                    consumed = 1'b0;
                end else if (it.ok && it.rv == want) begin
                    has_res = 1'b1;
                    res     = mk_res(KIND_DONE, '0, 1'b0, '0, ST_OK);
                end else begin
                    poll_cnt = poll_cnt + 1'b1;
                    if (poll_cnt >= reg_copy.feedback_poll_limit) begin
                        has_res = 1'b1;
                        res     = mk_res(KIND_DONE, '0, 1'b0, '0, ST_ERR);
                    end else begin
                        sq_phase = PH_ST_TICK;
                    end
                end
            end
            default: begin
                consumed = 1'b0;
                sq_phase = PH_IDLE;
            end
        endcase
        if (has_res && res.out_kind == KIND_DONE) begin
            sq_phase = PH_IDLE;
        end
    endtask

    // mode 0: noise, 1: random well-formed, 2: step toward a clean finish
    function automatic t_item gen_item(input int mode);
        t_item it;
        it.req    = 2'($urandom_range(3));
        it.target = 16'($urandom);
        it.ctrl   = 16'($urandom);
        it.stat   = 16'($urandom);
        it.ok     = 1'($urandom_range(1));
        it.rv     = 16'($urandom);
        if (mode == 0) begin
            return it;
        end
        it.ok = (mode == 2) || ($urandom_range(19) != 0);
        case (sq_phase)
            PH_IDLE: begin
                it.req = REQ_START;
                case ($urandom_range(9))
                    0: it.target = 16'h7FFF;
                    1: it.target = 16'h8000;
                    default: ;
                endcase
            end
            PH_SEL_WR, PH_OP_WR: it.req = REQ_WRSP;
            PH_SEL_RD: begin
                it.req = REQ_RRSP;
                if (mode == 2 || $urandom_range(1)) it.rv = reg_copy.select_feedback;
            end
            PH_EXE_RD: begin
                it.req = REQ_RRSP;
                if (mode == 2 || $urandom_range(1)) it.rv = reg_copy.execute_feedback;
            end
            PH_ST_RD: begin
                it.req = REQ_RRSP;
                if (mode == 2 || $urandom_range(1)) begin
                    it.rv = latched_target + reg_copy.operate_offset;
                end
            end
            default: it.req = REQ_TICK;
        endcase
        return it;
    endfunction

    task automatic send_item(input t_item it, input logic typed, input t_result typed_res,
                             output bit consumed);
        int      gap;
        bit      has_res;
        t_result res;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= it.req;
        i_target_value   <= it.target;
        i_control_device <= it.ctrl;
        i_status_device  <= it.stat;
        i_resp_ok        <= it.ok;
        i_read_value     <= it.rv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_sequencer(it, consumed, has_res, res);
        if (has_res) pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SELECT_OFFSET:       reg_copy.select_offset       = data;
            CFG_SELECT_FEEDBACK:     reg_copy.select_feedback     = data;
            CFG_OPERATE_OFFSET:      reg_copy.operate_offset      = data;
            CFG_EXECUTE_FEEDBACK:    reg_copy.execute_feedback    = data;
            CFG_SELECT_POLL_LIMIT:   reg_copy.select_poll_limit   = data;
            CFG_FEEDBACK_POLL_LIMIT: reg_copy.feedback_poll_limit = data;
            default: ;
        endcase
    endtask

    // hold until every expected result is out, then let the pipeline drain
    task automatic wait_idle;
        int waited;
        waited = 0;
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
            error_count += pending_results.size();
            pending_results.delete();
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [DataW-1:0] want,
                               input logic [DataW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d device %h",
                         $time, o_out_kind, o_device_id);
                error_count++;
            end else begin
                head = pending_results.pop_front();
                check_field("out_kind", 16'(head.out_kind), 16'(o_out_kind));
                check_field("device_id", head.device_id, o_device_id);
                check_field("point_sel", 16'(head.point_sel), 16'(o_point_sel));
                check_field("write_value", head.write_value, o_write_value);
                check_field("done_status", 16'(head.done_status), 16'(o_done_status));
            end
        end
    end

    // output stall: random, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                i_out_stall <= 1'b1;
                repeat (299) @(posedge i_clk);
                hold_pending = 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_row             row;
        bit               consumed;
        bit               prev_cfg;
        int               taken_items;
        logic [DataW-1:0] sel_lim;
        logic [DataW-1:0] fb_lim;
        logic [DataW-1:0] sel_off;
        logic [DataW-1:0] op_off;

        reset_model();
        dir_rows.push_back(with_res(it_row(REQ_START, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0, 16'h0),
                           mk_res(KIND_WRITE, 16'hFFFF, PT_CONTROL, 16'h7FFF, ST_OK)));
        dir_rows.push_back(it_row(REQ_TICK, 16'h0, 16'h0, 16'h0, 1'b1, 16'hFFFF));
        dir_rows.push_back(it_row(REQ_WRSP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0));
        dir_rows.push_back(with_res(it_row(REQ_TICK, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0),
                           mk_res(KIND_READ, 16'hFFFF, PT_CONTROL, 16'h0, ST_OK)));
        dir_rows.push_back(it_row(REQ_RRSP, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0));
        dir_rows.push_back(with_res(it_row(REQ_TICK, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0),
                           mk_res(KIND_WRITE, 16'hFFFF, PT_CONTROL, 16'h7FFF, ST_OK)));
        dir_rows.push_back(it_row(REQ_WRSP, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0));
        dir_rows.push_back(with_res(it_row(REQ_TICK, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0),
                           mk_res(KIND_READ, 16'h0000, PT_CONTROL, 16'h0, ST_OK)));
        dir_rows.push_back(it_row(REQ_RRSP, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0));
        dir_rows.push_back(with_res(it_row(REQ_TICK, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0),
                           mk_res(KIND_READ, 16'h0000, PT_CONTROL, 16'h0, ST_OK)));
        dir_rows.push_back(it_row(REQ_RRSP, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0));
        dir_rows.push_back(with_res(it_row(REQ_TICK, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0),
                           mk_res(KIND_READ, 16'h0000, PT_FEEDBACK, 16'h0, ST_OK)));
        dir_rows.push_back(with_res(it_row(REQ_RRSP, 16'h0, 16'h0, 16'h0, 1'b1, 16'h7FFF),
                           mk_res(KIND_DONE, 16'h0, 1'b0, 16'h0, ST_OK)));
        dir_rows.push_back(it_row(REQ_RRSP, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0));
        dir_rows.push_back(with_res(it_row(REQ_START, 16'h8000, 16'h0000, 16'hFFFF, 1'b1, 16'h0),
                           mk_res(KIND_WRITE, 16'h0000, PT_CONTROL, 16'h8000, ST_OK)));
        dir_rows.push_back(with_res(it_row(REQ_WRSP, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0),
                           mk_res(KIND_DONE, 16'h0, 1'b0, 16'h0, ST_ERR)));
        dir_rows.push_back(it_row(REQ_START, 16'h1234, 16'h00A5, 16'h5A00, 1'b0, 16'h0));
        dir_rows.push_back(it_row(REQ_WRSP, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0));
        dir_rows.push_back(it_row(REQ_TICK, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0));
        dir_rows.push_back(with_res(it_row(REQ_RRSP, 16'h0, 16'h0, 16'h0, 1'b0, 16'hFFFF),
                           mk_res(KIND_DONE, 16'h0, 1'b0, 16'h0, ST_ERR)));
        dir_rows.push_back(cfg_row(CFG_SELECT_POLL_LIMIT, 16'h0000));
        dir_rows.push_back(cfg_row(CFG_SELECT_OFFSET, 16'h7FFF));
        dir_rows.push_back(it_row(REQ_START, 16'h7FFF, 16'h0001, 16'h0002, 1'b0, 16'h0));
        dir_rows.push_back(with_res(it_row(REQ_WRSP, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0),
                           mk_res(KIND_DONE, 16'h0, 1'b0, 16'h0, ST_TIMEOUT)));
        dir_rows.push_back(cfg_row(CFG_SELECT_POLL_LIMIT, 16'h0001));
        dir_rows.push_back(cfg_row(CFG_FEEDBACK_POLL_LIMIT, 16'h0000));
        dir_rows.push_back(cfg_row(CFG_SELECT_FEEDBACK, 16'h8000));
        dir_rows.push_back(cfg_row(CFG_OPERATE_OFFSET, 16'h8000));
        dir_rows.push_back(cfg_row(CFG_EXECUTE_FEEDBACK, 16'hFFFF));
        dir_rows.push_back(it_row(REQ_START, 16'h7FFF, 16'hA5A5, 16'h5A5A, 1'b1, 16'h0));
        dir_rows.push_back(it_row(REQ_WRSP, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0));
        dir_rows.push_back(it_row(REQ_TICK, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0));
        dir_rows.push_back(it_row(REQ_RRSP, 16'h0, 16'h0, 16'h0, 1'b1, 16'h8000));
        dir_rows.push_back(it_row(REQ_TICK, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0));
        dir_rows.push_back(with_res(it_row(REQ_WRSP, 16'h0, 16'h0, 16'h0, 1'b1, 16'h0),
                           mk_res(KIND_DONE, 16'h0, 1'b0, 16'h0, ST_ERR)));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        prev_cfg = 1'b0;
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.is_cfg) begin
                if (!prev_cfg) wait_idle();
                write_reg(row.idx, row.data);
            end else begin
                i_cfg_valid <= 1'b0;
                send_item(row.it, row.typed, row.res, consumed);
            end
            prev_cfg = row.is_cfg;
        end

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    sel_lim       = 16'($urandom_range(2, 6));
                    fb_lim        = 16'($urandom_range(2, 6));
                    sel_off       = 16'($urandom);
                    op_off        = 16'($urandom);
                end
                1: begin
                    send_idle_pct = 60;
                    stall_pct     = 0;
                    sel_lim       = 16'hFFFF;
                    fb_lim        = 16'hFFFF;
                    sel_off       = 16'h7FFF;
                    op_off        = 16'h7FFF;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 60;
                    sel_lim       = 16'h0001;
                    fb_lim        = 16'h0001;
                    sel_off       = 16'h8000;
                    op_off        = 16'h8000;
                end
                default: begin
                    send_idle_pct = 30;
                    stall_pct     = 30;
                    sel_lim       = 16'($urandom_range(0, 6));
                    fb_lim        = 16'($urandom_range(0, 6));
                    sel_off       = 16'($urandom);
                    op_off        = 16'($urandom);
                end
            endcase
            write_reg(CFG_SELECT_OFFSET, sel_off);
            write_reg(CFG_SELECT_FEEDBACK, 16'($urandom));
            write_reg(CFG_OPERATE_OFFSET, op_off);
            write_reg(CFG_EXECUTE_FEEDBACK, 16'($urandom));
            write_reg(CFG_SELECT_POLL_LIMIT, sel_lim);
            write_reg(CFG_FEEDBACK_POLL_LIMIT, fb_lim);
            i_cfg_valid <= 1'b0;
            if (ph == 0) hold_pending = 1'b1;

            taken_items = 0;
            while (taken_items < 325) begin
                send_item(gen_item(($urandom_range(99) < 12) ? 0 : 1), 1'b0, '0, consumed);
                if (consumed) taken_items++;
            end
            // drive the open sequence to its end before touching registers
            while (sq_phase != PH_IDLE) begin
                send_item(gen_item(2), 1'b0, '0, consumed);
            end
        end

        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
